### hdl/pebs_pkg.sv
// Package for the peak element search block: request and response payloads,
// the job record passed from front to back, and the back-end state codes.
// No dependencies.
package pebs_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int VALUE_W            = 32;
   localparam int PEAK_W             = 10;
   localparam int JOB_CNT_W          = 17;
   localparam int NUM_BANKS          = 2;
   localparam int QUEUE_DEPTH        = 2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic [PEAK_W-1:0] peak_index;
      logic              found;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic                 bank;
      logic [JOB_CNT_W-1:0] count;
      logic                 overflow;
   } job_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_FIRST0,
      BS_FIRST1,
      BS_FIRST2,
      BS_LAST0,
      BS_LAST1,
      BS_LAST2,
      BS_MID,
      BS_LEFT,
      BS_RIGHT,
      BS_EVAL,
      BS_EMIT
   } back_state_type;

endpackage

### hdl/pebs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pebs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pebs_queue.sv
// Two-entry job queue between the loading front end and the search back end.
// Depends on pebs_pkg for the queue depth.
module pebs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(pebs_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pebs_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [pebs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_pop;

   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pebs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pebs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front end holds back once both banks are taken, so the queue never fills up.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != CNT_W'(pebs_pkg::QUEUE_DEPTH)))
      else $error("job queue pushed while full");

endmodule

### hdl/pebs_front.sv
// Front end: takes element requests, writes them into the current RAM bank
// and hands a finished array to the back end as a job. Depends on pebs_pkg.
module pebs_front #(
   parameter int DEPTH      = pebs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pebs_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pebs_pkg::req_type           req_data,
   output logic                        wr_en,
   output logic [$clog2(DEPTH):0]      wr_addr,
   output logic [DATA_WIDTH-1:0]       wr_data,
   output logic                        job_push,
   output pebs_pkg::job_type           job_data,
   input  logic                        release_bank
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PEND_W = $clog2(pebs_pkg::NUM_BANKS + 1);

   logic [CNT_W-1:0]  count_ff, count_in, count_next;
   logic              ov_ff, ov_in, ov_next;
   logic              bank_ff, bank_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              accept;

   assign req_stall = (pending_ff == PEND_W'(pebs_pkg::NUM_BANKS));
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (count_ff < CNT_W'(DEPTH));
   assign wr_addr   = {bank_ff, count_ff[IDX_W-1:0]};
   assign wr_data   = DATA_WIDTH'(req_data.value);

   assign count_next = wr_en ? count_ff + 1'b1 : count_ff;
   assign ov_next    = ov_ff || (accept && !wr_en);
   assign job_push   = accept && req_data.last;

   always_comb begin
      job_data.bank     = bank_ff;
      job_data.count    = pebs_pkg::JOB_CNT_W'(count_next);
      job_data.overflow = ov_next;
      count_in = count_next;
      ov_in    = ov_next;
      bank_in  = bank_ff;
      if (job_push) begin
         count_in = '0;
         ov_in    = 1'b0;
         bank_in  = !bank_ff;
      end
      pending_in = pending_ff;
      if (job_push && !release_bank) begin
         pending_in = pending_ff + 1'b1;
      end else if (release_bank && !job_push) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ov_ff      <= 1'b0;
         bank_ff    <= 1'b0;
         pending_ff <= '0;
      end else begin
         count_ff   <= count_in;
         ov_ff      <= ov_in;
         bank_ff    <= bank_in;
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(pebs_pkg::NUM_BANKS))
      else $error("more arrays pending than there are banks");

   a_release_has_job: assert property (@(posedge clock) disable iff (reset)
      release_bank |-> (pending_ff != '0))
      else $error("bank released with no array pending");

endmodule

### hdl/pebs_back.sv
// Back end: takes a job from the queue, searches its RAM bank for a peak and
// holds the response in an output register. Depends on pebs_pkg.
module pebs_back #(
   parameter int DEPTH      = pebs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pebs_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  pebs_pkg::job_type      job_data,
   output logic                   job_pop,
   output logic [$clog2(DEPTH):0] rd_addr,
   input  logic [DATA_WIDTH-1:0]  rd_data,
   output logic                   release_bank,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pebs_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pebs_pkg::back_state_type state_ff, state_in;

   logic                         bank_ff, bank_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic                         ov_ff, ov_in;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic [CNT_W-1:0]             lo_ff, lo_in;
   logic [CNT_W-1:0]             hi_ff, hi_in;
   logic [CNT_W-1:0]             mid_ff, mid_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pebs_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic [CNT_W:0]               mid_sum;
   logic [IDX_W-1:0]             rd_idx;
   logic signed [DATA_WIDTH-1:0] rd_value;
   logic [CNT_W-1:0]             job_count;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in    = mid_sum[CNT_W:1];
   assign rd_value  = $signed(rd_data);
   assign rd_addr   = {bank_ff, rd_idx};
   assign job_count = CNT_W'(job_data.count);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      n_in         = n_ff;
      ov_in        = ov_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      release_bank = 1'b0;
      rd_idx       = '0;
      case (state_ff)
         pebs_pkg::BS_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               bank_in = job_data.bank;
               n_in    = job_count;
               ov_in   = job_data.overflow;
               if (job_count <= CNT_W'(1)) begin
                  found_in = 1'b1;
                  idx_in   = '0;
                  state_in = pebs_pkg::BS_EMIT;
               end else begin
                  state_in = pebs_pkg::BS_FIRST0;
               end
            end
         end
         pebs_pkg::BS_FIRST0: begin
            rd_idx   = '0;
            state_in = pebs_pkg::BS_FIRST1;
         end
         pebs_pkg::BS_FIRST1: begin
            rd_idx   = IDX_W'(1);
            x_in     = rd_value;
            state_in = pebs_pkg::BS_FIRST2;
         end
         pebs_pkg::BS_FIRST2: begin
            if (x_ff > rd_value) begin
               found_in = 1'b1;
               idx_in   = '0;
               state_in = pebs_pkg::BS_EMIT;
            end else begin
               state_in = pebs_pkg::BS_LAST0;
            end
         end
         pebs_pkg::BS_LAST0: begin
            rd_idx   = IDX_W'(n_ff - CNT_W'(1));
            state_in = pebs_pkg::BS_LAST1;
         end
         pebs_pkg::BS_LAST1: begin
            rd_idx   = IDX_W'(n_ff - CNT_W'(2));
            x_in     = rd_value;
            state_in = pebs_pkg::BS_LAST2;
         end
         pebs_pkg::BS_LAST2: begin
            if (x_ff > rd_value) begin
               found_in = 1'b1;
               idx_in   = n_ff - CNT_W'(1);
               state_in = pebs_pkg::BS_EMIT;
            end else begin
               lo_in    = CNT_W'(1);
               hi_in    = n_ff - CNT_W'(2);
               state_in = pebs_pkg::BS_MID;
            end
         end
         pebs_pkg::BS_MID: begin
            rd_idx = IDX_W'(mid_in);
            if (lo_ff > hi_ff) begin
               found_in = 1'b0;
               idx_in   = '0;
               state_in = pebs_pkg::BS_EMIT;
            end else begin
               state_in = pebs_pkg::BS_LEFT;
            end
         end
         pebs_pkg::BS_LEFT: begin
            rd_idx   = IDX_W'(mid_ff - CNT_W'(1));
            x_in     = rd_value;
            state_in = pebs_pkg::BS_RIGHT;
         end
         pebs_pkg::BS_RIGHT: begin
            rd_idx   = IDX_W'(mid_ff + CNT_W'(1));
            y_in     = rd_value;
            state_in = pebs_pkg::BS_EVAL;
         end
         pebs_pkg::BS_EVAL: begin
            if ((x_ff > y_ff) && (x_ff > rd_value)) begin
               found_in = 1'b1;
               idx_in   = mid_ff;
               state_in = pebs_pkg::BS_EMIT;
            end else if (x_ff > y_ff) begin
               lo_in    = mid_ff + CNT_W'(1);
               state_in = pebs_pkg::BS_MID;
            end else begin
               hi_in    = mid_ff - CNT_W'(1);
               state_in = pebs_pkg::BS_MID;
            end
         end
         pebs_pkg::BS_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.peak_index = pebs_pkg::PEAK_W'(idx_ff);
               rsp_data_in.found      = found_ff;
               rsp_data_in.overflow   = ov_ff;
               release_bank           = 1'b1;
               state_in               = pebs_pkg::BS_IDLE;
            end
         end
         default: begin
            state_in = pebs_pkg::BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pebs_pkg::BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      n_ff        <= n_in;
      ov_ff       <= ov_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= (state_ff == pebs_pkg::BS_MID) ? mid_in : mid_ff;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_start_needs_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pebs_pkg::BS_IDLE && state_in != pebs_pkg::BS_IDLE) |-> job_valid)
      else $error("search started without a queued job");

   a_search_low_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pebs_pkg::BS_MID) |-> (lo_ff != '0))
      else $error("binary search lower bound reached index zero");

   a_not_found_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.peak_index == '0))
      else $error("response without a peak carries a non-zero index");

endmodule

### hdl/peak_element_binary_search_top.sv
// Peak element search over a streamed array: one element is taken per request
// and, after the request marked last, one response gives the index of a peak or
// flags that none was found. Storage for two arrays lets the next array load
// while the previous one is searched. Elements load at one per cycle while a
// bank is free. A search first checks the elements at both ends and then runs
// binary-search probes through states MID, LEFT, RIGHT and EVAL, paced by the
// single read port of the element RAM. When both banks hold arrays awaiting
// search or delivery, requests are stalled. Elements beyond DEPTH are dropped
// and flagged as overflow in the response. There is no clearing pass after reset.
// Depends on pebs_pkg, pebs_front, pebs_queue, pebs_back and pebs_ram.
module peak_element_binary_search_top #(
   parameter int DEPTH      = pebs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pebs_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pebs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pebs_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH) + 1;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  job_push;
   pebs_pkg::job_type     job_push_data;
   logic                  job_pop;
   logic                  job_valid;
   pebs_pkg::job_type     job_pop_data;
   logic                  release_bank;

   pebs_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .job_push     (job_push),
      .job_data     (job_push_data),
      .release_bank (release_bank)
   );

   pebs_queue #(
      .WIDTH ($bits(pebs_pkg::job_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (job_pop_data)
   );

   pebs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pebs_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_data     (job_pop_data),
      .job_pop      (job_pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .release_bank (release_bank),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
